// ===== sv/f32bc_pkg.sv =====
// Shared types, constants and arithmetic for the Fletcher-32 byte checksum.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package f32bc_pkg;

  localparam int unsigned SumW  = 16;
  localparam int unsigned ByteW = 8;
  localparam int unsigned CsumW = 2 * SumW;

  localparam logic [SumW-1:0] SUM_INIT = 16'hFFFF;

  typedef logic [SumW-1:0]  sum_t;
  typedef logic [ByteW-1:0] byte_t;
  typedef logic [CsumW-1:0] csum_t;

  // One input item as it travels from the input register to the accumulator.
  typedef struct packed {
    byte_t data_byte;
    logic  last_byte;
  } item_t;

  // Ones-complement add on 16 bits: fold the carry back into bit 0.
  function automatic sum_t oc_add(input sum_t x, input sum_t y);
    logic [SumW:0] s;
    logic [SumW:0] f;
    s = {1'b0, x} + {1'b0, y};
    f = {1'b0, s[SumW-1:0]} + {{SumW{1'b0}}, s[SumW]};
    return f[SumW-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/f32bc_accum.sv =====
// Running sums A and B plus word assembly state for the Fletcher-32 block.
// Depends on f32bc_pkg; instantiated by fletcher32_byte_checksum.
`timescale 1ns / 1ps
`default_nettype none

module f32bc_accum (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,
  input  wire f32bc_pkg::item_t item_i,
  output f32bc_pkg::csum_t     checksum_o
);
  import f32bc_pkg::*;

  sum_t  sum_a_q, sum_a_d;
  sum_t  sum_b_q, sum_b_d;
  byte_t pending_low_q, pending_low_d;
  logic  holding_low_q, holding_low_d;
  logic  word_seen_q, word_seen_d;

  sum_t  word;
  logic  do_add;
  sum_t  a_new;
  sum_t  b_new;

  always_comb begin
    word   = holding_low_q ? {item_i.data_byte, pending_low_q}
                           : {{(SumW-ByteW){1'b0}}, item_i.data_byte};
    do_add = holding_low_q || (item_i.last_byte && word_seen_q);
    a_new  = oc_add(sum_a_q, word);
    b_new  = oc_add(sum_b_q, a_new);

    checksum_o = do_add ? {b_new, a_new} : {sum_b_q, sum_a_q};

    sum_a_d       = sum_a_q;
    sum_b_d       = sum_b_q;
    pending_low_d = pending_low_q;
    holding_low_d = holding_low_q;
    word_seen_d   = word_seen_q;
    if (item_i.last_byte) begin
      // message ends: return to the start state
      sum_a_d       = SUM_INIT;
      sum_b_d       = SUM_INIT;
      pending_low_d = '0;
      holding_low_d = 1'b0;
      word_seen_d   = 1'b0;
    end else if (holding_low_q) begin
      sum_a_d       = a_new;
      sum_b_d       = b_new;
      pending_low_d = '0;
      holding_low_d = 1'b0;
      word_seen_d   = 1'b1;
    end else begin
      pending_low_d = item_i.data_byte;
      holding_low_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_a_q       <= SUM_INIT;
      sum_b_q       <= SUM_INIT;
      pending_low_q <= '0;
      holding_low_q <= 1'b0;
      word_seen_q   <= 1'b0;
    end else if (step_i) begin
      sum_a_q       <= sum_a_d;
      sum_b_q       <= sum_b_d;
      pending_low_q <= pending_low_d;
      holding_low_q <= holding_low_d;
      word_seen_q   <= word_seen_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/fletcher32_byte_checksum.sv =====
// Top level of the Fletcher-32 byte-stream checksum: input register,
// accumulator and result register. Depends on f32bc_pkg and f32bc_accum.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one message byte per item
//   in data_byte_i, with last_byte_i set on the final byte of a message.
//   Byte pairs form little-endian words; sums A and B start at 0xFFFF.
//   Output channel (out_valid_o / out_ready_i) carries one item per message:
//   checksum_o = {B, A}. A one-byte message yields 0xFFFFFFFF.
// Timing:
//   One byte is accepted every cycle while no final byte is held back. A byte
//   lands in the input register, then the accumulator folds it into A and B
//   as it leaves that register; on the last byte the result register
//   loads too, so out_valid_o rises as the last byte leaves that register.
//   The accumulator's add path is one word add into A followed by one add of A
//   into B, both with end-around carry.
// Reset and stall:
//   rst_ni clears both sums to 0xFFFF and empties both registers.
//   While a result waits to be taken, non-final bytes keep flowing into
//   the sums; only a final byte holds in the input register until the
//   result register frees up.
`timescale 1ns / 1ps
`default_nettype none

module fletcher32_byte_checksum (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire f32bc_pkg::byte_t  data_byte_i,
  input  wire logic              last_byte_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output f32bc_pkg::csum_t       checksum_o
);
  import f32bc_pkg::*;

  // Input register
  logic  in_vld_q;
  item_t item_q;

  // Result register
  logic  out_vld_q;
  csum_t csum_q;

  logic  out_free;
  logic  advance;
  csum_t csum_next;

  // Hold a final byte until the result slot is free; non-final bytes
  // advance whenever present.
  assign out_free   = !out_vld_q || out_ready_i;
  assign advance    = in_vld_q && (!item_q.last_byte || out_free);
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= '{data_byte: data_byte_i, last_byte: last_byte_i};
    end
  end

  f32bc_accum u_accum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .item_i     (item_q),
    .checksum_o (csum_next)
  );

  // Load the result on a final byte; drop valid once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && item_q.last_byte) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && item_q.last_byte) begin
      csum_q <= csum_next;
    end
  end

  assign out_valid_o = out_vld_q;
  assign checksum_o  = csum_q;

endmodule

`default_nettype wire

// ===== tb/fletcher32_byte_checksum_tb.sv =====
// Self-checking testbench for fletcher32_byte_checksum: random byte messages with
// random stalls on both channels, checked against an in-bench Fletcher-32 predictor.
// Depends on f32bc_pkg and the fletcher32_byte_checksum RTL.
`timescale 1ns / 1ps

module fletcher32_byte_checksum_tb;
  import f32bc_pkg::*;

  // Cycles without any item moving on either channel before the run is declared hung.
  // The longest legal quiet stretch is the forced receiver hold-off plus a gap.
  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned LongHoldCycles = 400;
  localparam int unsigned TargetBytes = 1300;
  localparam int unsigned MaxPrints = 40;

  typedef enum int unsigned {
    FILL_RANDOM,
    FILL_ONES,
    FILL_ZEROS,
    FILL_RAMP
  } fill_e;

  // One byte waiting to be sent; drain_first makes the sender wait for all
  // outstanding checksums before offering it.
  typedef struct packed {
    byte_t data;
    logic  last;
    logic  drain_first;
  } pend_t;

  logic  clk_i       = 1'b0;
  logic  rst_ni      = 1'b0;
  logic  in_valid_i  = 1'b0;
  byte_t data_byte_i = '0;
  logic  last_byte_i = 1'b0;
  logic  out_ready_i = 1'b0;
  logic  in_ready_o;
  logic  out_valid_o;
  csum_t checksum_o;

  fletcher32_byte_checksum dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .checksum_o  (checksum_o)
  );

  pend_t byte_q[$];   // bytes not yet offered
  csum_t csum_q[$];   // checksums predicted but not yet received

  // Predictor state: running sums, half-built word, and whether a full word
  // has gone into the sums for the current message.
  sum_t  run_a     = SUM_INIT;
  sum_t  run_b     = SUM_INIT;
  byte_t low_byte  = '0;
  logic  low_held  = 1'b0;
  logic  have_word = 1'b0;

  logic        in_fire  = 1'b0;  // input item taken at the last rising edge
  int unsigned results_seen = 0;
  int unsigned err_cnt = 0;
  int unsigned idle_cnt = 0;
  int unsigned msg_cnt = 0;
  int unsigned byte_cnt = 0;
  int unsigned lone_cnt = 0;
  int unsigned odd_cnt = 0;
  int unsigned in_stall_cnt = 0;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // 16-bit add with end-around carry.
  function automatic sum_t ones_add(input sum_t x, input sum_t y);
    logic [SumW:0] s;
    s = x + y;
    return s[SumW-1:0] + sum_t'(s[SumW]);
  endfunction

  task automatic add_word(input sum_t w);
    run_a = ones_add(run_a, w);
    run_b = ones_add(run_b, run_a);
  endtask

  // Fold one accepted byte into the predicted sums; on the last byte, queue
  // the expected checksum and start over for the next message.
  task automatic fold_byte(input byte_t b, input logic last);
    if (low_held) begin
      add_word({b, low_byte});
      have_word = 1'b1;
      low_held  = 1'b0;
      low_byte  = '0;
    end else if (last) begin
      // Trailing odd byte counts only after a full word; a lone byte is dropped.
      if (have_word) add_word({8'h00, b});
    end else begin
      low_byte = b;
      low_held = 1'b1;
    end
    if (last) begin
      csum_q.push_back({run_b, run_a});
      run_a     = SUM_INIT;
      run_b     = SUM_INIT;
      low_byte  = '0;
      low_held  = 1'b0;
      have_word = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string what, input csum_t got, input csum_t want);
    err_cnt++;
    if (err_cnt <= MaxPrints)
      $display("%0t: checksum %s: got %08h, expected %08h", $time, what, got, want);
  endtask

  // Mostly zero-length gaps, some short, a few long; now and then a run of
  // back-to-back cycles with no gap at all.
  function automatic int unsigned pick_gap(inout int unsigned run_left);
    int unsigned r;
    if (run_left != 0) begin
      run_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      run_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Bias toward the extreme byte values so that folding happens often.
  function automatic byte_t pick_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 8'hFF;
    if (r < 16) return 8'h00;
    return byte_t'($urandom_range(0, 255));
  endfunction

  task automatic queue_message(input int unsigned len, input fill_e fill, input logic drain);
    pend_t it;
    for (int unsigned i = 0; i < len; i++) begin
      case (fill)
        FILL_ONES:  it.data = 8'hFF;
        FILL_ZEROS: it.data = 8'h00;
        FILL_RAMP:  it.data = byte_t'(i + 1);
        default:    it.data = pick_byte();
      endcase
      it.last        = (i == len - 1);
      it.drain_first = drain && (i == 0);
      byte_q.push_back(it);
    end
    msg_cnt++;
    byte_cnt += len;
    if (len == 1) lone_cnt++;
    else if (len % 2 == 1) odd_cnt++;
  endtask

  // Monitor: predict on every accepted input item, check every accepted result.
  // Predict first so a same-edge result always finds its expectation queued.
  always @(posedge clk_i or negedge rst_ni) begin
    csum_t want;
    if (!rst_ni) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid_i && in_ready_o;
      if (in_valid_i && !in_ready_o) in_stall_cnt <= in_stall_cnt + 1;
      if (in_valid_i && in_ready_o) fold_byte(data_byte_i, last_byte_i);
      if (out_valid_o && out_ready_i) begin
        if (csum_q.size() == 0) begin
          report_mismatch("with nothing pending", checksum_o, '0);
        end else begin
          want = csum_q.pop_front();
          if (checksum_o[SumW-1:0] !== want[SumW-1:0])
            report_mismatch("sum A wrong", checksum_o, want);
          else if (checksum_o[CsumW-1:SumW] !== want[CsumW-1:SumW])
            report_mismatch("sum B wrong", checksum_o, want);
        end
        results_seen <= results_seen + 1;
      end
    end
  end

  // Sender: hold the current item until taken, then advance after a random gap.
  // An item flagged drain_first stays back until every checksum has come home.
  always @(negedge clk_i) begin
    pend_t it;
    static int unsigned send_gap = 0;
    static int unsigned send_run = 0;
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (send_gap != 0) begin
        in_valid_i <= 1'b0;
        send_gap--;
      end else if (byte_q.size() != 0 && !(byte_q[0].drain_first && csum_q.size() != 0)) begin
        it = byte_q.pop_front();
        in_valid_i  <= 1'b1;
        data_byte_i <= it.data;
        last_byte_i <= it.last;
        send_gap = pick_gap(send_run);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off once a dozen results are in,
  // which backs the block up until it refuses input.
  always @(negedge clk_i) begin
    static int unsigned hold_cnt = 0;
    static int unsigned recv_run = 0;
    static logic        long_hold_done = 1'b0;
    int unsigned g;
    if (rst_ni) begin
      if (hold_cnt != 0) begin
        out_ready_i <= 1'b0;
        hold_cnt--;
      end else if (!long_hold_done && results_seen >= 12) begin
        long_hold_done = 1'b1;
        hold_cnt = LongHoldCycles - 1;
        out_ready_i <= 1'b0;
      end else begin
        g = pick_gap(recv_run);
        if (g == 0) begin
          out_ready_i <= 1'b1;
        end else begin
          out_ready_i <= 1'b0;
          hold_cnt = g - 1;
        end
      end
    end
  end

  // Watchdog: count cycles in which no item moves on either channel.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cnt <= 0;
      end else if (idle_cnt + 1 >= WatchdogLimit) begin
        $display("%0t: no progress for %0d cycles", $time, WatchdogLimit);
        $display("FAILED: results differ");
        $finish;
      end else begin
        idle_cnt <= idle_cnt + 1;
      end
    end
  end

  initial begin
    int unsigned r;
    int unsigned len;
    int unsigned n_rand;

    // Directed: lone bytes at both extremes, even and odd messages, and a run of
    // 0xFF bytes that forces end-around carries in both sums.
    queue_message(1, FILL_ZEROS, 1'b0);
    queue_message(1, FILL_ONES, 1'b0);
    queue_message(2, FILL_ZEROS, 1'b0);
    queue_message(2, FILL_ONES, 1'b0);
    queue_message(3, FILL_RAMP, 1'b0);
    queue_message(3, FILL_ONES, 1'b0);
    queue_message(5, FILL_ZEROS, 1'b0);
    queue_message(8, FILL_ONES, 1'b0);

    // Random: mostly short messages, a few long ones; now and then a message
    // whose first byte waits for the block to drain completely.
    n_rand = 0;
    while (byte_cnt < TargetBytes) begin
      r = $urandom_range(0, 99);
      if (r < 10) len = 1;
      else if (r < 80) len = $urandom_range(2, 12);
      else if (r < 95) len = $urandom_range(13, 40);
      else len = $urandom_range(41, 120);
      r = $urandom_range(0, 99);
      queue_message(len,
                    (r < 85) ? FILL_RANDOM : (r < 92) ? FILL_ONES :
                    (r < 96) ? FILL_ZEROS : FILL_RAMP,
                    (n_rand == 0) || (n_rand == 60) || ($urandom_range(0, 49) == 0));
      n_rand++;
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Drain: every byte taken, every checksum back, then an idle stretch for strays.
    while (byte_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (csum_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Sent %0d bytes in %0d messages (%0d lone-byte, %0d odd-length).",
             byte_cnt, msg_cnt, lone_cnt, odd_cnt);
    $display("Checked %0d checksums; input stalled by the block on %0d cycles.",
             results_seen, in_stall_cnt);
    if (err_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== fletcher32_byte_checksum.f =====
sv/f32bc_pkg.sv
sv/f32bc_accum.sv
sv/fletcher32_byte_checksum.sv
tb/fletcher32_byte_checksum_tb.sv
